@@ rtl/convolution_background_adjust_top_macros.svh @@
// Assertion macros shared by the convolution background adjust RTL.
// Every user must have clk and rst_n (synchronous, active low) in scope.
`ifndef CONVOLUTION_BACKGROUND_ADJUST_TOP_MACROS_SVH
`define CONVOLUTION_BACKGROUND_ADJUST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define CBA_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ rtl/cba_pkg.sv @@
// Shared types and constants of the convolution background adjust block.
// No dependencies; used by cba_divider and the top level.
`default_nettype none
package cba_pkg;

  localparam int WORD_W    = 24;  // intensity word
  localparam int ALPHA_W   = 32;
  localparam int TAG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // alpha*sigma^2 in intensity units fits in 45 bits for every fraction width
  // from 4 upward; the difference a needs two more bits for sign and headroom.
  localparam int AS2_W = 45;
  localparam int A_W   = AS2_W + 2;

  // z is kept in Q.16; only |z| below 16 (a raw Q.16 value below 2^20) needs a real quotient.
  localparam int Z_FRAC = 16;
  localparam int Q_W    = 20;
  localparam int N_W    = 28 + Z_FRAC;
  localparam int ROM_W  = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MU    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 2'd2;

  localparam logic [WORD_W-1:0] SIGMA_RESET = 24'd256;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic                  neg;
    logic                  ovf;
    logic [TAG_W-1:0]      tag;
    logic                  last;
  } div_ctl_t;

endpackage
`default_nettype wire

@@ rtl/convolution_background_adjust_top.sv @@
// Top level of the convolution background adjust block: config registers,
// arithmetic pipeline and ratio ROM. Depends on cba_pkg, cba_divider and the macros header.
//
// Usage. Each input word (raw_intensity, column_tag, last_probe) is taken at
// a clock edge where start is high and busy is low; busy stays low, so a
// word may be presented in every cycle. The block returns
// a + sigma*phi(a/sigma)/Phi(a/sigma) with a = x - mu - alpha*sigma^2,
// saturated to 0..2^24-1, with tag and last flag copied.
// out_valid is high for exactly one cycle per result, once the word has passed
// every stage, and one result leaves per cycle at full rate.
// The pipeline holds 5 front stages (square, alpha products, scaling,
// subtract, magnitude), the 20-stage z divider and 7 stages of table
// interpolation, sigma product and saturation.
// The receiver cannot stall; results are never held.
// Configuration is written through cfg_valid/cfg_ready (always ready) with
// cfg_index 0 = mu, 1 = alpha, 2 = sigma; other indices are ignored. Write
// only while no word is in flight. A sigma of zero acts as one.
// Reset is synchronous: it empties the pipeline and loads mu = 0, alpha = 0
// and sigma = 256.
`default_nettype none
`include "convolution_background_adjust_top_macros.svh"
module convolution_background_adjust_top #(
  parameter int RATIO_TABLE_DEPTH = 512,
  parameter int FRACTION_BITS     = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [cba_pkg::WORD_W-1:0]     in_raw_intensity,
  input  wire logic [cba_pkg::TAG_W-1:0]      in_column_tag,
  input  wire logic                           in_last_probe,
  output logic                                out_valid,
  output logic [cba_pkg::WORD_W-1:0]          out_corrected_intensity,
  output logic [cba_pkg::TAG_W-1:0]           out_column_tag_out,
  output logic                                out_last_probe_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cba_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import cba_pkg::*;

  localparam int IDX_W    = $clog2(RATIO_TABLE_DEPTH);
  localparam int U_W      = Q_W + 1;
  localparam int P_W      = U_W + IDX_W;
  localparam int SHIFT    = 16 + FRACTION_BITS;
  localparam int LATENCY  = 12 + Q_W;
  localparam int SIDE_LEN = 5;
  localparam logic [Q_W-1:0]  Z_LIM   = Q_W'(8 << Z_FRAC);
  localparam logic [U_W-1:0]  U_TOP   = U_W'(1) << Q_W;
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(RATIO_TABLE_DEPTH - 1);

  // Ratio table generator: Heun integration of r' = -r(z+r) in Q.24.
  localparam int     SUBSTEPS = 64;
  localparam longint STEPS    = longint'(RATIO_TABLE_DEPTH - 1) * SUBSTEPS;
  localparam longint STEPS2   = 2 * STEPS;
  localparam longint SPAN     = longint'(16) << 24;
  localparam longint BASE     = -(longint'(8) << 24);
  localparam longint Q24_ONE  = longint'(1) << 24;
  localparam longint R_START  = 136253949;

  typedef logic [ROM_W-1:0] rom_t [RATIO_TABLE_DEPTH];

  function automatic rom_t gen_rom();
    rom_t   tbl;
    longint r, j, z0, z1, g1, g2, rp;
    int     k, s;
    r = R_START;
    j = 0;
    tbl[0] = ROM_W'((r + 128) >>> 8);
    for (k = 1; k < RATIO_TABLE_DEPTH; k++) begin
      for (s = 0; s < SUBSTEPS; s++) begin
        z0 = BASE + (j * SPAN) / STEPS;
        z1 = BASE + ((j + 1) * SPAN) / STEPS;
        g1 = (r * (z0 + r)) / Q24_ONE;
        rp = r - (16 * g1) / STEPS;
        if (rp < 0) rp = 0;
        g2 = (rp * (z1 + rp)) / Q24_ONE;
        r  = r - (16 * (g1 + g2)) / STEPS2;
        if (r < 0) r = 0;
        j++;
      end
      tbl[k] = ROM_W'((r + 128) >>> 8);
    end
    return tbl;
  endfunction

  localparam rom_t RATIO_ROM = gen_rom();

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic                  zlow;
    logic [TAG_W-1:0]      tag;
    logic                  last;
  } side_t;

  // Configuration registers.
  logic [WORD_W-1:0]  mu_r, sigma_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [WORD_W-1:0]  sg;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign sg        = (sigma_r == '0) ? WORD_W'(1) : sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= '0;
      alpha_r <= '0;
      sigma_r <= SIGMA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MU:    mu_r    <= cfg_data[WORD_W-1:0];
        REG_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
        REG_SIGMA: sigma_r <= cfg_data[WORD_W-1:0];
        default:   ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Front stages A..E.
  logic                  v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic [WORD_W-1:0]     x_a_r, x_b_r, x_c_r;
  logic [TAG_W-1:0]      tag_a_r, tag_b_r, tag_c_r, tag_d_r;
  logic                  last_a_r, last_b_r, last_c_r, last_d_r;
  logic [2*WORD_W-1:0]   s2_a_r;
  logic [63:0]           mhi_b_r, mlo_b_r;
  logic [64:0]           as2_sum;
  logic [AS2_W-1:0]      as2_c_r;
  logic signed [A_W-1:0] a_d_r, a_nxt;
  logic [A_W-1:0]        mag;
  logic [N_W-1:0]        num_e_r;
  div_ctl_t              ctl_e_r, ctl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
    end else begin
      v_a_r <= accept;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
    end
  end

  assign as2_sum = {1'b0, mhi_b_r} + 65'(mlo_b_r >> 16);
  assign a_nxt   = A_W'(signed'({1'b0, x_c_r})) - A_W'(signed'({1'b0, mu_r}))
                 - A_W'(signed'({1'b0, as2_c_r}));
  assign mag     = a_d_r[A_W-1] ? A_W'(-a_d_r) : A_W'(a_d_r);

  always_comb begin
    ctl_nxt      = '0;
    ctl_nxt.a    = a_d_r;
    ctl_nxt.neg  = a_d_r[A_W-1];
    ctl_nxt.ovf  = (mag >= (A_W'(sg) << 4));
    ctl_nxt.tag  = tag_d_r;
    ctl_nxt.last = last_d_r;
  end

  always_ff @(posedge clk) begin
    x_a_r    <= in_raw_intensity;
    tag_a_r  <= in_column_tag;
    last_a_r <= in_last_probe;
    s2_a_r   <= (2*WORD_W)'(sg) * (2*WORD_W)'(sg);
    x_b_r    <= x_a_r;
    tag_b_r  <= tag_a_r;
    last_b_r <= last_a_r;
    mhi_b_r  <= 64'(s2_a_r) * 64'(alpha_r[31:16]);
    mlo_b_r  <= 64'(s2_a_r) * 64'(alpha_r[15:0]);
    x_c_r    <= x_b_r;
    tag_c_r  <= tag_b_r;
    last_c_r <= last_b_r;
    as2_c_r  <= AS2_W'(as2_sum >> SHIFT);
    a_d_r    <= a_nxt;
    tag_d_r  <= tag_c_r;
    last_d_r <= last_c_r;
    num_e_r  <= {mag[N_W-Z_FRAC-1:0], {Z_FRAC{1'b0}}};
    ctl_e_r  <= ctl_nxt;
  end

  // z = a / sigma in Q.16, magnitude only.
  logic            v_q;
  logic [Q_W-1:0]  quot;
  div_ctl_t        ctl_q;

  cba_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_e_r),
    .in_num    (num_e_r),
    .den       (sg),
    .in_ctl    (ctl_e_r),
    .out_valid (v_q),
    .out_quot  (quot),
    .out_ctl   (ctl_q)
  );

  // Stage F: table coordinate u = z + 8, clamped; z below -8 gives zero out.
  logic            big;
  logic [U_W-1:0]  u_nxt, u_f_r;
  side_t           side_nxt;
  logic            v_f_r;
  side_t           side_f_r;

  assign big = ctl_q.ovf || (quot > Z_LIM);

  always_comb begin
    side_nxt      = '0;
    side_nxt.a    = ctl_q.a;
    side_nxt.zlow = ctl_q.neg && big;
    side_nxt.tag  = ctl_q.tag;
    side_nxt.last = ctl_q.last;
    priority if (big) begin
      u_nxt = ctl_q.neg ? '0 : U_TOP;
    end else if (ctl_q.neg) begin
      u_nxt = U_W'(Z_LIM) - U_W'(quot);
    end else begin
      u_nxt = U_W'(Z_LIM) + U_W'(quot);
    end
  end

  // Stages G..L share one sideband shift line.
  logic [SIDE_LEN-1:0] v_line_r;
  side_t               side_line_r [SIDE_LEN];
  logic [P_W-1:0]      p_g_r;
  logic [IDX_W-1:0]    idx0, idx1;
  logic [ROM_W-1:0]    rom0_h_r, rom1_h_r;
  logic [Q_W-1:0]      f_h_r;
  logic [ROM_W+U_W-1:0] w0_i_r, w1_i_r;
  logic [ROM_W+U_W:0]   wsum;
  logic [ROM_W-1:0]    ratio_j_r;
  logic [WORD_W+ROM_W-1:0] prod_k_r;
  logic signed [A_W:0] corr;
  logic [WORD_W-1:0]   corr_sat;
  logic                v_l_r;
  logic [WORD_W-1:0]   corr_l_r;
  logic [TAG_W-1:0]    tag_l_r;
  logic                last_l_r;

  assign idx0 = p_g_r[Q_W +: IDX_W];
  assign idx1 = (idx0 == IDX_END) ? idx0 : idx0 + IDX_W'(1);
  assign wsum = (ROM_W+U_W+1)'(w0_i_r) + (ROM_W+U_W+1)'(w1_i_r);
  assign corr = (A_W+1)'(side_line_r[4].a)
              + (A_W+1)'(signed'({1'b0, prod_k_r[WORD_W+ROM_W-1:Z_FRAC]}));

  always_comb begin
    priority if (side_line_r[4].zlow || corr < 0) begin
      corr_sat = '0;
    end else if (corr > (A_W+1)'({WORD_W{1'b1}})) begin
      corr_sat = '1;
    end else begin
      corr_sat = corr[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r    <= 1'b0;
      v_line_r <= '0;
      v_l_r    <= 1'b0;
    end else begin
      v_f_r    <= v_q;
      v_line_r <= {v_line_r[SIDE_LEN-2:0], v_f_r};
      v_l_r    <= v_line_r[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    u_f_r          <= u_nxt;
    side_f_r       <= side_nxt;
    side_line_r[0] <= side_f_r;
    for (int k = 1; k < SIDE_LEN; k++) begin
      side_line_r[k] <= side_line_r[k-1];
    end
    p_g_r     <= P_W'(u_f_r) * P_W'(RATIO_TABLE_DEPTH - 1);
    rom0_h_r  <= RATIO_ROM[idx0];
    rom1_h_r  <= RATIO_ROM[idx1];
    f_h_r     <= p_g_r[Q_W-1:0];
    w0_i_r    <= (ROM_W+U_W)'(rom0_h_r) * (ROM_W+U_W)'(U_TOP - U_W'(f_h_r));
    w1_i_r    <= (ROM_W+U_W)'(rom1_h_r) * (ROM_W+U_W)'(f_h_r);
    ratio_j_r <= wsum[Q_W +: ROM_W];
    prod_k_r  <= (WORD_W+ROM_W)'(sg) * (WORD_W+ROM_W)'(ratio_j_r);
    corr_l_r  <= corr_sat;
    tag_l_r   <= side_line_r[4].tag;
    last_l_r  <= side_line_r[4].last;
  end

  assign out_valid               = v_l_r;
  assign out_corrected_intensity = corr_l_r;
  assign out_column_tag_out      = tag_l_r;
  assign out_last_probe_out      = last_l_r;

  `CBA_ASSERT_DELAY(a_latency, accept, LATENCY, out_valid,
    "accepted word did not produce a result after the pipeline latency")
  `CBA_ASSERT_NEXT(a_zlow_zero, v_line_r[4] && side_line_r[4].zlow,
    out_corrected_intensity == '0, "deep negative z did not give zero")
  `CBA_ASSERT_NEXT(a_sigma_write, cfg_valid && cfg_ready && cfg_index == REG_SIGMA,
    sigma_r == $past(cfg_data[WORD_W-1:0]), "sigma write not taken")

endmodule
`default_nettype wire

@@ rtl/cba_divider.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on cba_pkg and on convolution_background_adjust_top_macros.svh.
`default_nettype none
`include "convolution_background_adjust_top_macros.svh"
module cba_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [cba_pkg::N_W-1:0]     in_num,
  input  wire logic [cba_pkg::WORD_W-1:0]  den,
  input  wire cba_pkg::div_ctl_t           in_ctl,
  output logic                             out_valid,
  output logic [cba_pkg::Q_W-1:0]          out_quot,
  output cba_pkg::div_ctl_t                out_ctl
);
  import cba_pkg::*;

  logic [Q_W-1:0] vld_r;
  logic [N_W-1:0] rem_r  [Q_W];
  logic [Q_W-1:0] quot_r [Q_W];
  div_ctl_t       ctl_r  [Q_W];

  // Stage g decides quotient bit Q_W-1-g; the remainder stays below den
  // shifted by that bit position plus one.
  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic           v_in;
    logic [N_W-1:0] rem_in;
    logic [Q_W-1:0] quot_in;
    div_ctl_t       ctl_in;
    logic [N_W-1:0] dsh;
    logic           ge;

    if (g == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign quot_in = '0;
      assign ctl_in  = in_ctl;
    end else begin : g_rest
      assign v_in    = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quot_in = quot_r[g-1];
      assign ctl_in  = ctl_r[g-1];
    end

    assign dsh = N_W'(den) << (Q_W - 1 - g);
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= ge ? (rem_in - dsh) : rem_in;
      quot_r[g] <= {quot_in[Q_W-2:0], ge};
      ctl_r[g]  <= ctl_in;
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quot  = quot_r[Q_W-1];
  assign out_ctl   = ctl_r[Q_W-1];

  `CBA_ASSERT_NOW(a_num_in_range, in_valid && !in_ctl.ovf,
    in_num < (N_W'(den) << Q_W), "divider fed a quotient that does not fit")
  `CBA_ASSERT_NOW(a_rem_below_den, out_valid && !out_ctl.ovf,
    rem_r[Q_W-1] < N_W'(den), "divider remainder not below divisor")
  `CBA_ASSERT_DELAY(a_valid_travel, in_valid, Q_W, out_valid,
    "divider word did not leave after its stage count")

endmodule
`default_nettype wire

@@ tb/cba_checker.sv @@
`timescale 1ns / 1ps
// Checker for the convolution background adjust block: it follows the input, result
// and register write channels, predicts each corrected word and compares it. Uses cba_pkg.
module cba_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [cba_pkg::WORD_W-1:0]     in_raw_intensity,
  input  wire logic [cba_pkg::TAG_W-1:0]      in_column_tag,
  input  wire logic                           in_last_probe,
  input  wire logic                           out_valid,
  input  wire logic [cba_pkg::WORD_W-1:0]     out_corrected_intensity,
  input  wire logic [cba_pkg::TAG_W-1:0]      out_column_tag_out,
  input  wire logic                           out_last_probe_out,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cba_pkg::CFG_DAT_W-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  words_in_flight
);
  import cba_pkg::*;

  localparam int DEPTH = 512;
  localparam int FRAC = 8;
  localparam int SUBSTEPS = 64;
  localparam longint Z_LIM = longint'(8) <<< 16;

  typedef struct packed {
    logic [WORD_W-1:0] corrected;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } probe_result_t;

  longint ratio_table [DEPTH];
  logic [WORD_W-1:0]  mu_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [WORD_W-1:0]  sigma_q;
  probe_result_t      expected_words [$];

  // Heun integration of r' = -r(z+r) from z = -8 upward, all in Q.24.
  initial begin
    longint steps, span, base, r, j, z0, z1, g1, g2, rp;
    steps = longint'(DEPTH - 1) * SUBSTEPS;
    span  = longint'(16) <<< 24;
    base  = -(longint'(8) <<< 24);
    r = 136253949;
    j = 0;
    ratio_table[0] = (r + 128) >>> 8;
    for (int k = 1; k < DEPTH; k++) begin
      for (int s = 0; s < SUBSTEPS; s++) begin
        z0 = base + (j * span) / steps;
        z1 = base + ((j + 1) * span) / steps;
        g1 = (r * (z0 + r)) / (longint'(1) <<< 24);
        rp = r - (16 * g1) / steps;
        if (rp < 0) rp = 0;
        g2 = (rp * (z1 + rp)) / (longint'(1) <<< 24);
        r = r - (16 * (g1 + g2)) / (2 * steps);
        if (r < 0) r = 0;
        j++;
      end
      ratio_table[k] = (r + 128) >>> 8;
    end
  end

  function automatic logic [WORD_W-1:0] corrected_intensity(logic [WORD_W-1:0] x);
    bit [63:0] sg, s2, as2, ratio, p, i, f;
    longint a, zq, corr;
    sg  = (sigma_q == 0) ? 64'd1 : 64'(sigma_q);
    s2  = sg * sg;
    as2 = (s2 * 64'(alpha_q[31:16]) + ((s2 * 64'(alpha_q[15:0])) >> 16)) >> (16 + FRAC);
    a   = longint'(x) - longint'(mu_q) - longint'(as2);
    zq  = (a * 65536) / longint'(sg);
    if (zq < -Z_LIM) begin
      ratio = 64'(-zq);
    end else begin
      if (zq > Z_LIM) zq = Z_LIM;
      p = 64'(zq + Z_LIM) * (DEPTH - 1);
      i = p >> 20;
      f = p & 64'hFFFFF;
      if (i >= DEPTH - 1) ratio = 64'(ratio_table[DEPTH-1]);
      else ratio = (64'(ratio_table[i]) * (64'h100000 - f)
                    + 64'(ratio_table[i+1]) * f) >> 20;
    end
    corr = a + longint'((sg * ratio) >> 16);
    if (corr < 0) corr = 0;
    if (corr > 64'hFFFFFF) corr = 64'hFFFFFF;
    return corr[WORD_W-1:0];
  endfunction

  assign words_in_flight = expected_words.size();

  always @(posedge clk) begin
    probe_result_t want;
    if (!rst_n) begin
      mu_q    <= '0;
      alpha_q <= '0;
      sigma_q <= SIGMA_RESET;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MU:    mu_q    <= cfg_data[WORD_W-1:0];
          REG_ALPHA: alpha_q <= cfg_data;
          REG_SIGMA: sigma_q <= cfg_data[WORD_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        want.corrected = corrected_intensity(in_raw_intensity);
        want.tag  = in_column_tag;
        want.last = in_last_probe;
        expected_words = {expected_words, want};
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: actual %h/%h/%b", $time,
                   out_corrected_intensity, out_column_tag_out, out_last_probe_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.corrected !== out_corrected_intensity || want.tag !== out_column_tag_out
              || want.last !== out_last_probe_out) begin
            $display("%0t: mismatch: expected %h/%h/%b actual %h/%h/%b", $time,
                     want.corrected, want.tag, want.last, out_corrected_intensity,
                     out_column_tag_out, out_last_probe_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the convolution background adjust testbench: clock, reset, register phases
// and probe stimulus. Depends on cba_pkg, the block and cba_checker.
module tb_top;
  import cba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [WORD_W-1:0] in_raw_intensity = '0;
  logic [TAG_W-1:0]  in_column_tag = '0;
  logic              in_last_probe = 1'b0;
  logic              out_valid;
  logic [WORD_W-1:0] out_corrected_intensity;
  logic [TAG_W-1:0]  out_column_tag_out;
  logic              out_last_probe_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int fail_count;
  int words_in_flight;
  int words_sent = 0;
  logic [WORD_W-1:0] mu_now = '0;
  logic [ALPHA_W-1:0] alpha_now = '0;
  logic [WORD_W-1:0] sigma_now = SIGMA_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  convolution_background_adjust_top i_dut (
    .clk, .rst_n, .start, .busy, .in_raw_intensity, .in_column_tag, .in_last_probe,
    .out_valid, .out_corrected_intensity, .out_column_tag_out, .out_last_probe_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cba_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_raw_intensity, .in_column_tag, .in_last_probe,
    .out_valid, .out_corrected_intensity, .out_column_tag_out, .out_last_probe_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .words_in_flight
  );

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MU) mu_now = value[WORD_W-1:0];
    if (idx == REG_ALPHA) alpha_now = value;
    if (idx == REG_SIGMA) sigma_now = value[WORD_W-1:0];
  endtask

  // Start stays high across back-to-back words; it drops only for an idle cycle.
  task automatic send_probe(logic [WORD_W-1:0] x, logic [TAG_W-1:0] tag, logic last);
    bit calm;
    calm = (words_sent >= 700 && words_sent < 1000);
    while (!calm && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_raw_intensity <= x;
    in_column_tag <= tag;
    in_last_probe <= last;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (words_in_flight != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Half of the words land within 12 sigma of a centre set by mu, alpha and sigma, where the ratio matters.
  function automatic logic [WORD_W-1:0] pick_intensity();
    longint centre, spread, v;
    bit [63:0] s;
    s = (sigma_now == 0) ? 64'd1 : 64'(sigma_now);
    centre = longint'(mu_now) + longint'(((s * s) >> 24) * 64'(alpha_now) >> 32);
    spread = longint'(s) * 12;
    case ($urandom_range(3))
      0: return WORD_W'($urandom);
      1: return WORD_W'($urandom_range(4095));
      default: begin
        v = centre + longint'($urandom_range(2 * 30000)) * spread / 30000 - spread;
        if (v < 0) v = 0;
        if (v > 24'hFFFFFF) v = 24'hFFFFFF;
        return v[WORD_W-1:0];
      end
    endcase
  endfunction

  initial begin
    logic [CFG_DAT_W-1:0] mu_set [8] = '{0, 24'hFFFFFF, 1000, 0, 24'h123456, 0, 500, 0};
    logic [CFG_DAT_W-1:0] alpha_set [8] =
      '{0, 32'hFFFFFFFF, 32'h00010000, 32'hFFFFFFFF, 32'h80000000, 0, 32'h0000FFFF, 0};
    logic [CFG_DAT_W-1:0] sigma_set [8] =
      '{256, 24'hFFFFFF, 1, 0, 4000, 24'hFFFFFF, 64, 2};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: zero offset, zero in z, top of range, both tag and flag extremes.
    send_probe(24'd0, 8'd0, 1'b0);
    send_probe(24'hFFFFFF, 8'hFF, 1'b1);
    send_probe(24'd256, 8'h55, 1'b0);
    send_probe(24'd2304, 8'hAA, 1'b1);
    send_probe(24'd1, 8'd1, 1'b0);
    drain();

    // Deep negative z (large mu, tiny sigma, a write to an unused index), zero sigma and huge sigma.
    write_reg(REG_MU, 24'hFFFFFF);
    write_reg(REG_SIGMA, 32'd1);
    write_reg(2'd3, 32'hFFFFFFFF);
    send_probe(24'd0, 8'd7, 1'b1);
    send_probe(24'hFFFFFF, 8'd8, 1'b0);
    send_probe(24'hFFFFF0, 8'd9, 1'b1);
    drain();
    write_reg(REG_MU, 32'd0);
    write_reg(REG_SIGMA, 32'd0);
    send_probe(24'd0, 8'd10, 1'b0);
    send_probe(24'd20, 8'd11, 1'b1);
    send_probe(24'hFFFFFF, 8'd12, 1'b0);
    drain();
    write_reg(REG_SIGMA, 32'hFFFFFFFF);
    write_reg(REG_ALPHA, 32'hFFFFFFFF);
    send_probe(24'd0, 8'd13, 1'b1);
    send_probe(24'hFFFFFF, 8'd14, 1'b0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 8) begin
        write_reg(REG_MU, mu_set[ph]);
        write_reg(REG_ALPHA, alpha_set[ph]);
        write_reg(REG_SIGMA, sigma_set[ph]);
      end else begin
        write_reg(REG_MU, $urandom);
        write_reg(REG_ALPHA, $urandom);
        write_reg(REG_SIGMA, $urandom_range(2000));
      end
      repeat (195) send_probe(pick_intensity(), TAG_W'($urandom), 1'($urandom));
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
